// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BSR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsr property violated");

// Condition that must never be seen outside reset.
`define BSR_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bsr forbidden condition seen");

`endif

// ----- hw/rtl/bsr_pkg.sv -----
// Package for the Braille sparkline renderer: sizes, register indexes,
// payload and control structs, controller states, cell encode functions.
// No dependencies.
package bsr_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 4;
  localparam int MAX_SAMPLES = 256;

  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int GX_W       = COL_W + 1;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int GY_W       = ROW_W + 2;
  localparam int SAMPLE_AW  = $clog2(MAX_SAMPLES);
  localparam int CNT_W      = SAMPLE_AW + 1;
  localparam int DIV_CNT_W  = $clog2(SAMPLE_AW);

  localparam int SAMPLE_W   = 16;
  localparam int Q_FRAC     = 14;
  localparam int UV_W       = Q_FRAC + 1;
  localparam int PROD_W     = UV_W + GY_W;
  localparam logic [UV_W-1:0]   Q_ONE  = UV_W'(1 << Q_FRAC);
  localparam logic [PROD_W-1:0] Q_HALF = PROD_W'(1 << (Q_FRAC - 1));

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_COLUMNS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_CAPACITY = 2'd2;
  localparam logic [4:0] COLUMNS_RST  = 5'd16;
  localparam logic [2:0] ROWS_RST     = 3'd4;
  localparam logic [7:0] CAPACITY_RST = 8'd255;

  // Output byte budget
  localparam int LEN_W = 9;
  localparam int SUM_W = LEN_W + 1;
  localparam logic [SUM_W-1:0] CELL_BYTES = SUM_W'(3);

  // UTF-8 encoding of the Braille block
  localparam logic [15:0] CP_BASE    = 16'h2800;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [7:0]  UTF8_MASK6 = 8'h3F;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } bsr_in_t;

  typedef struct packed {
    logic [7:0] dot_mask;
    logic [7:0] utf8_lead;
    logic [7:0] utf8_middle;
    logic [7:0] utf8_trail;
    logic       newline_after;
    logic       final_cell;
  } bsr_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_COL_RD,
    ST_COL_WR,
    ST_EMIT
  } bsr_state_e;

  typedef struct packed {
    logic load;        // store the accepted sample
    logic start;       // last sample taken: set up the render
    logic div_step;    // one quotient bit
    logic col_write;   // place the dot of the current column
    logic emit_init;   // rewind cell walk and byte count
    logic emit_load;   // put the current cell in the output register
  } bsr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic col_last;
    logic slot_free;
    logic cell_ok;
    logic cell_final;
  } bsr_status_t;

  // Braille dot bit for a sub-row (0..3) and side (0 left, 1 right).
  function automatic logic [7:0] dot_bit(input logic [1:0] sub_row, input logic side);
    logic [7:0] bits;
    bits = 8'h00;
    unique case (sub_row)
      2'd0: bits = side ? 8'h08 : 8'h01;
      2'd1: bits = side ? 8'h10 : 8'h02;
      2'd2: bits = side ? 8'h20 : 8'h04;
      2'd3: bits = side ? 8'h80 : 8'h40;
      default: bits = 8'h00;
    endcase
    return bits;
  endfunction

  function automatic bsr_out_t encode_cell(input logic [7:0] mask,
                                           input logic newline,
                                           input logic last_cell);
    bsr_out_t    o;
    logic [15:0] cp;
    cp              = CP_BASE + {8'h00, mask};
    o.dot_mask      = mask;
    o.utf8_lead     = UTF8_LEAD3 | {4'h0, cp[15:12]};
    o.utf8_middle   = UTF8_CONT | (cp[13:6] & UTF8_MASK6);
    o.utf8_trail    = UTF8_CONT | (cp[7:0] & UTF8_MASK6);
    o.newline_after = newline;
    o.final_cell    = last_cell;
    return o;
  endfunction

endpackage

// ----- hw/rtl/bsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bsr_ctrl.sv -----
// Controller of the sparkline renderer: load, divide, column walk, cell emit.
// Depends on bsr_pkg.
module bsr_ctrl import bsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_last_i,
  input  bsr_status_t status_i,
  output logic        in_stall_o,
  output bsr_cmd_t    cmd_o
);

  bsr_state_e state_q, state_d;
  logic       take;

  assign take = in_valid_i && (state_q == ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (take && in_last_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_COL_RD;
      end
      ST_COL_RD: state_d = ST_COL_WR;
      ST_COL_WR: begin
        state_d = status_i.col_last ? ST_EMIT : ST_COL_RD;
      end
      ST_EMIT: begin
        // leave on the last cell, or at once when not even one cell fits
        if (status_i.slot_free && (!status_i.cell_ok || status_i.cell_final)) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = take;
        cmd_o.start = take && in_last_i;
      end
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_COL_RD: ;
      ST_COL_WR: begin
        cmd_o.col_write = 1'b1;
        cmd_o.emit_init = status_i.col_last;
      end
      ST_EMIT: begin
        cmd_o.emit_load = status_i.slot_free && status_i.cell_ok;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/bsr_datapath.sv -----
// Datapath of the sparkline renderer: config registers, sample store,
// index divider, column heights, cell encoder and output register.
// Depends on bsr_pkg and bsr_ram.
module bsr_datapath import bsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  bsr_in_t               in_data_i,
  input  bsr_cmd_t              cmd_i,
  input  logic                  out_stall_i,
  output bsr_status_t           status_o,
  output logic                  out_valid_o,
  output bsr_out_t              out_data_o
);

  // Configuration
  logic [4:0] cols_cfg_q;
  logic [2:0] rows_cfg_q;
  logic [7:0] cap_q;
  logic [4:0] cols_c;
  logic [2:0] rows_c;
  logic [4:0] cols_m1;
  logic [2:0] rows_m1;
  logic [GX_W-1:0] div_d;     // 2*cols-1
  logic [GY_W-1:0] gh_m1;     // 4*rows-1

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= COLUMNS_RST;
      rows_cfg_q <= ROWS_RST;
      cap_q      <= CAPACITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CELL_COLUMNS:  cols_cfg_q <= cfg_data_i[4:0];
        CFG_CELL_ROWS:     rows_cfg_q <= cfg_data_i[2:0];
        CFG_BYTE_CAPACITY: cap_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cols_cfg_q == 5'd0) cols_c = 5'd1;
    else if (cols_cfg_q > 5'(MAX_COLUMNS)) cols_c = 5'(MAX_COLUMNS);
    else cols_c = cols_cfg_q;
    priority if (rows_cfg_q == 3'd0) rows_c = 3'd1;
    else if (rows_cfg_q > 3'(MAX_ROWS)) rows_c = 3'(MAX_ROWS);
    else rows_c = rows_cfg_q;
  end

  assign cols_m1 = cols_c - 5'd1;
  assign rows_m1 = rows_c - 3'd1;
  assign div_d   = {cols_m1[COL_W-1:0], 1'b1};
  assign gh_m1   = {rows_m1[ROW_W-1:0], 2'b11};

  // Sample store
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 room;
  logic [SAMPLE_AW-1:0] dividend;
  logic [SAMPLE_AW-1:0] si_q, si_d;
  logic [SAMPLE_W-1:0]  rd_data;

  assign room     = count_q < CNT_W'(MAX_SAMPLES);
  // n-1 where n counts this last sample unless the store was full
  assign dividend = room ? count_q[SAMPLE_AW-1:0] : SAMPLE_AW'(count_q - CNT_W'(1));

  always_comb begin
    count_d = count_q;
    if (cmd_i.start) begin
      count_d = '0;
    end else if (cmd_i.load && room) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  bsr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && room),
    .waddr_i (count_q[SAMPLE_AW-1:0]),
    .wdata_i (in_data_i.sample),
    .raddr_i (si_q),
    .rdata_o (rd_data)
  );

  // Restoring divider: (n-1) / (2*cols-1), one quotient bit a cycle
  logic [SAMPLE_AW-1:0] quo_q;
  logic [GX_W-1:0]      rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [GX_W:0]        rem_shift;
  logic                 rem_ge;

  assign rem_shift = {rem_q, quo_q[SAMPLE_AW-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q     <= dividend;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q     <= {quo_q[SAMPLE_AW-2:0], rem_ge};
      rem_q     <= rem_ge ? GX_W'(rem_shift - {1'b0, div_d}) : rem_shift[GX_W-1:0];
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  // Column walk: sample index advances by quotient plus remainder carry
  logic [GX_W-1:0] gx_q;
  logic [GX_W-1:0] acc_q, acc_d;
  logic [GX_W:0]   acc_sum;
  logic            acc_wrap;

  assign acc_sum  = {1'b0, acc_q} + {1'b0, rem_q};
  assign acc_wrap = acc_sum >= {1'b0, div_d};
  assign acc_d    = acc_wrap ? GX_W'(acc_sum - {1'b0, div_d}) : acc_sum[GX_W-1:0];
  assign si_d     = si_q + quo_q + SAMPLE_AW'(acc_wrap);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      gx_q  <= '0;
      si_q  <= '0;
      acc_q <= '0;
    end else if (cmd_i.col_write) begin
      gx_q  <= gx_q + GX_W'(1);
      si_q  <= si_d;
      acc_q <= acc_d;
    end
  end

  // Dot row of the column: round((1-v)*(4*rows-1))
  logic [UV_W-1:0]   uv;
  logic [UV_W-1:0]   diff;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] rounded;
  logic [GY_W:0]     gy_raw;
  logic [GY_W-1:0]   gy;

  always_comb begin
    priority if (rd_data[SAMPLE_W-1]) uv = '0;
    else if (rd_data[SAMPLE_W-2:0] > (SAMPLE_W-1)'(Q_ONE)) uv = Q_ONE;
    else uv = rd_data[UV_W-1:0];
  end

  assign diff    = Q_ONE - uv;
  assign prod    = PROD_W'(diff) * PROD_W'(gh_m1);
  assign rounded = prod + Q_HALF;
  assign gy_raw  = rounded[PROD_W-1:Q_FRAC];
  assign gy      = (gy_raw > {1'b0, gh_m1}) ? gh_m1 : gy_raw[GY_W-1:0];

  // One dot per column: keep its row, left and right column of each cell
  logic [GY_W-1:0] left_gy_q  [MAX_COLUMNS];
  logic [GY_W-1:0] right_gy_q [MAX_COLUMNS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_write) begin
      if (gx_q[0]) begin
        right_gy_q[gx_q[GX_W-1:1]] <= gy;
      end else begin
        left_gy_q[gx_q[GX_W-1:1]] <= gy;
      end
    end
  end

  // Cell walk and byte budget
  logic [COL_W-1:0] cx_q;
  logic [ROW_W-1:0] cy_q;
  logic [LEN_W-1:0] len_q;
  logic [GY_W-1:0]  gl, gr;
  logic [7:0]       mask;
  logic             row_end, last_row;
  logic [SUM_W-1:0] len_w, cap_w;
  logic             cell_ok, nl_ok, next_same_ok, next_row_ok;
  logic             newline, cell_final;

  assign gl = left_gy_q[cx_q];
  assign gr = right_gy_q[cx_q];

  always_comb begin
    mask = 8'h00;
    if (gl[GY_W-1:2] == cy_q) mask = mask | dot_bit(gl[1:0], 1'b0);
    if (gr[GY_W-1:2] == cy_q) mask = mask | dot_bit(gr[1:0], 1'b1);
  end

  assign row_end      = {1'b0, cx_q} == cols_m1;
  assign last_row     = {1'b0, cy_q} == rows_m1;
  assign len_w        = {1'b0, len_q};
  assign cap_w        = SUM_W'(cap_q);
  assign cell_ok      = (len_w + SUM_W'(4)) < cap_w;
  assign nl_ok        = (len_w + SUM_W'(5)) < cap_w;
  assign next_same_ok = (len_w + SUM_W'(7)) < cap_w;
  assign next_row_ok  = (len_w + SUM_W'(8)) < cap_w;
  assign newline      = row_end && nl_ok;
  assign cell_final   = row_end ? (!nl_ok || last_row || !next_row_ok) : !next_same_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_init) begin
      cx_q  <= '0;
      cy_q  <= '0;
      len_q <= '0;
    end else if (cmd_i.emit_load) begin
      len_q <= LEN_W'(len_w + CELL_BYTES + SUM_W'(newline));
      if (row_end) begin
        cx_q <= '0;
        cy_q <= cy_q + ROW_W'(1);
      end else begin
        cx_q <= cx_q + COL_W'(1);
      end
    end
  end

  // Output register
  logic     out_valid_q, out_valid_d;
  bsr_out_t out_q;

  always_comb begin
    priority if (cmd_i.emit_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q <= encode_cell(mask, newline, cell_final);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.div_last   = div_cnt_q == DIV_CNT_W'(SAMPLE_AW - 1);
  assign status_o.col_last   = gx_q == div_d;
  assign status_o.slot_free  = !out_valid_q || !out_stall_i;
  assign status_o.cell_ok    = cell_ok;
  assign status_o.cell_final = cell_final;

endmodule

// ----- hw/rtl/braille_sparkline_renderer.sv -----
// Top level of the Braille sparkline renderer: controller plus datapath.
// Depends on bsr_pkg, bsr_ctrl, bsr_datapath.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------
//   in       | input     | in_valid_i / in_stall_o | in_data_i  (bsr_in_t)
//   out      | output    | out_valid_o/out_stall_i | out_data_o (bsr_out_t)
//   cfg      | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// A sample that is not marked last is stored while the input stays unstalled.
// A last sample starts a render, with the input stalled: the index divider, then
// a sample store read and a dot placement per dot column, then the cell emit.
// Reset clears control state and restores the register reset values; the
// sample store is not cleared. A stalled output register holds the cell walk.
module braille_sparkline_renderer import bsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bsr_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bsr_out_t              out_data_o
);

  bsr_cmd_t    cmd;
  bsr_status_t status;

  bsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_sample),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  bsr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/bsr_checker.sv -----
// Port-level checks for the Braille sparkline renderer, bound to the top level.
// Depends on bsr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsr_checker import bsr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input bsr_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bsr_out_t out_data_o
);

  // a stalled cell stays in place
  `BSR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // every cell lies in the Braille block, so the lead byte is fixed
  `BSR_ASSERT_NEVER(a_lead_byte, clk_i, rst_ni, out_valid_o && (out_data_o.utf8_lead != 8'hE2))

  // continuation bytes carry the dot mask
  `BSR_ASSERT(a_cont_bytes, clk_i, rst_ni, out_valid_o |-> (out_data_o.utf8_trail == {2'b10, out_data_o.dot_mask[5:0]}) && (out_data_o.utf8_middle == {6'b101000, out_data_o.dot_mask[7:6]}))

  // a last sample transfer starts a render, which holds off input
  `BSR_ASSERT(a_last_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.last_sample |=> in_stall_o)

endmodule

bind braille_sparkline_renderer bsr_checker u_bsr_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for braille_sparkline_renderer: random bursts of samples in,
// cells out with a random stall pattern. An inline predictor models the plot and the byte budget.
// Depends on bsr_pkg and the renderer RTL.
`timescale 1ns / 1ps

module tb;
  import bsr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind this index
  localparam int Q14_ONE       = 1 << Q_FRAC;
  localparam int GRID_STRIDE   = 2 * MAX_COLUMNS;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 110;
  // Braille dot weights, indexed by sub_row*2 + side
  localparam logic [63:0] DOT_WEIGHTS = {8'h80, 8'h40, 8'h20, 8'h04,
                                         8'h10, 8'h02, 8'h08, 8'h01};

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  bsr_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bsr_out_t out_data_o;

  braille_sparkline_renderer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic [4:0] columns_reg = COLUMNS_RST;
  logic [2:0] rows_reg = ROWS_RST;
  logic [7:0] capacity_reg = CAPACITY_RST;
  logic signed [SAMPLE_W-1:0] sample_mem [MAX_SAMPLES];
  int unsigned samples_held = 0;

  bsr_in_t  samples_pending[$];
  bsr_out_t cells_due[$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;

  // Build the cells of one plot from the held samples and append them to cells_due.
  function automatic void render_plot();
    int unsigned cols, rows, gw, gh, gx, gy, si, len, cx, cy, sy, sx;
    int v;
    logic [7:0] mask;
    logic [15:0] cp;
    logic [GRID_STRIDE*4*MAX_ROWS-1:0] dots;
    bit stop;
    bsr_out_t plot_cell;
    bsr_out_t plot[$];
    cols = (columns_reg == 0) ? 1 : ((columns_reg > MAX_COLUMNS) ? MAX_COLUMNS : columns_reg);
    rows = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    gw = 2 * cols;
    gh = 4 * rows;
    dots = '0;
    if (capacity_reg == 0) return;
    for (gx = 0; gx < gw; gx++) begin
      si = (samples_held <= 1) ? 0 : (gx * (samples_held - 1)) / (gw - 1);
      v = sample_mem[si];
      if (v < 0) v = 0;
      if (v > Q14_ONE) v = Q14_ONE;
      gy = ((Q14_ONE - v) * (gh - 1) + Q14_ONE / 2) / Q14_ONE;
      if (gy >= gh) gy = gh - 1;
      dots[gy * GRID_STRIDE + gx] = 1'b1;
    end
    len = 0;
    stop = 1'b0;
    for (cy = 0; cy < rows && !stop; cy++) begin
      for (cx = 0; cx < cols && !stop; cx++) begin
        mask = '0;
        for (sy = 0; sy < 4; sy++)
          for (sx = 0; sx < 2; sx++)
            if (dots[(cy * 4 + sy) * GRID_STRIDE + cx * 2 + sx])
              mask |= DOT_WEIGHTS[(sy * 2 + sx) * 8 +: 8];
        if (len + 4 >= capacity_reg) begin
          stop = 1'b1;
        end else begin
          cp = 16'h2800 + {8'h00, mask};
          plot_cell.dot_mask      = mask;
          plot_cell.utf8_lead     = 8'hE0 | {4'h0, cp[15:12]};
          plot_cell.utf8_middle   = 8'h80 | {2'b00, cp[11:6]};
          plot_cell.utf8_trail    = 8'h80 | {2'b00, cp[5:0]};
          plot_cell.newline_after = 1'b0;
          plot_cell.final_cell    = 1'b0;
          plot.push_back(plot_cell);
          len += 3;
        end
      end
      if (!stop) begin
        if (len + 2 >= capacity_reg) begin
          stop = 1'b1;
        end else begin
          plot[plot.size() - 1].newline_after = 1'b1;
          len += 1;
        end
      end
    end
    if (plot.size() > 0) plot[plot.size() - 1].final_cell = 1'b1;
    foreach (plot[i]) cells_due.push_back(plot[i]);
  endfunction

  // Store an accepted sample; a last sample renders the plot and rewinds the store.
  function automatic void take_sample(input bsr_in_t s);
    if (samples_held < MAX_SAMPLES) begin
      sample_mem[samples_held] = s.sample;
      samples_held++;
    end
    items_taken++;
    if (s.last_sample) begin
      render_plot();
      samples_held = 0;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) take_sample(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (samples_pending.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= samples_pending.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted cell; the stall mode is picked anew at random
  int unsigned stall_cycle = 0;
  int unsigned stall_mode = 0;
  bsr_out_t cell_due;

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected cell, expected none actual mask %0h",
                   $time, out_data_o.dot_mask);
          mismatches++;
        end else begin
          cell_due = cells_due.pop_front();
          check_field("dot_mask", cell_due.dot_mask, out_data_o.dot_mask);
          check_field("utf8_lead", cell_due.utf8_lead, out_data_o.utf8_lead);
          check_field("utf8_middle", cell_due.utf8_middle, out_data_o.utf8_middle);
          check_field("utf8_trail", cell_due.utf8_trail, out_data_o.utf8_trail);
          check_field("newline_after", cell_due.newline_after, out_data_o.newline_after);
          check_field("final_cell", cell_due.final_cell, out_data_o.final_cell);
        end
      end
      stall_cycle++;
      if (stall_cycle % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: out_stall_i <= stall_cycle[3];
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_CELL_COLUMNS:  columns_reg = data[4:0];
      CFG_CELL_ROWS:     rows_reg = data[2:0];
      CFG_BYTE_CAPACITY: capacity_reg = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_plot_shape(input logic [7:0] cols, input logic [7:0] rows,
                                input logic [7:0] cap);
    write_reg(CFG_CELL_COLUMNS, cols);
    write_reg(CFG_CELL_ROWS, rows);
    write_reg(CFG_BYTE_CAPACITY, cap);
  endtask

  task automatic queue_sample(input logic [15:0] value, input logic last);
    bsr_in_t s;
    s.sample = value;
    s.last_sample = last;
    samples_pending.push_back(s);
    items_queued++;
  endtask

  // Mostly in-range values, some anywhere in the 16-bit range
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom_range(0, Q14_ONE));
    endcase
  endfunction

  task automatic queue_plot(input int n);
    for (int i = 0; i < n; i++) queue_sample(pick_sample(), i == n - 1);
  endtask

  // Wait for every transfer and result, then let any render without output finish.
  task automatic settle();
    while (items_taken != items_queued || cells_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned random_start;
    logic [7:0] cols, rows, cap;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset shape; single-sample plot, then the sample extremes
    queue_sample(16'h7FFF, 1'b1);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'h2000, 1'b0);
    queue_sample(16'h4000, 1'b0);
    queue_sample(16'h4001, 1'b0);
    queue_sample(16'hFFFF, 1'b0);
    queue_sample(16'h2EE0, 1'b0);
    queue_sample(16'h1000, 1'b1);
    settle();

    // Zero shape registers act as one; spare index must be ignored
    set_plot_shape(8'h00, 8'h00, 8'd255);
    write_reg(CFG_SPARE, 8'hA5);
    queue_sample(16'h4000, 1'b0);
    queue_sample(16'h0000, 1'b1);
    settle();

    // Oversized shape saturates; zero capacity emits nothing
    set_plot_shape(8'h1F, 8'h07, 8'd0);
    queue_sample(16'h1234, 1'b1);
    settle();

    // Budget boundaries: first cell only, then one newline, then no cell at all
    set_plot_shape(8'h05, 8'h02, 8'd5);
    queue_plot(3);
    settle();
    set_plot_shape(8'h01, 8'h02, 8'd6);
    queue_plot(2);
    settle();
    set_plot_shape(8'h10, 8'h04, 8'd4);
    queue_plot(2);
    settle();

    // Random shapes and plots
    random_start = items_queued;
    while (items_queued - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: cols = 8'($urandom_range(0, 255));
        1: cols = 8'd16;
        default: cols = {3'($urandom), 5'($urandom_range(1, 16))};
      endcase
      rows = ($urandom_range(0, 3) == 0) ? 8'($urandom) : {5'($urandom), 3'($urandom_range(1, 4))};
      case ($urandom_range(0, 5))
        0: cap = 8'd0;
        1: cap = 8'($urandom_range(1, 24));
        2, 3: cap = 8'd255;
        default: cap = 8'($urandom);
      endcase
      set_plot_shape(cols, rows, cap);
      repeat ($urandom_range(2, 4))
        queue_plot(($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
      settle();
    end

    set_plot_shape(8'd1, 8'd1, 8'd255);
    queue_plot(1);
    queue_plot(7);
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
